@@ src/video_port_interface_macros.svh @@
// ============================================================================
// Video port interface assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ============================================================================
`ifndef VIDEO_PORT_INTERFACE_MACROS_SVH
`define VIDEO_PORT_INTERFACE_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define VPI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("video_port_interface: implication check failed");

// ante holds in a cycle -> cons holds in the next cycle
`define VPI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("video_port_interface: next-cycle check failed");

`endif

@@ src/vpi_pkg.sv @@
// ============================================================================
// Video port interface package
// Sizes, access kinds, codes, reset values and state encoding.
// ============================================================================
package vpi_pkg;

    localparam int VRAM_DEPTH = 16384;   // power of two
    localparam int CRAM_DEPTH = 32;      // power of two
    localparam int REG_COUNT  = 11;

    localparam int VRAM_AW = $clog2(VRAM_DEPTH);
    localparam int CRAM_AW = $clog2(CRAM_DEPTH);

    localparam int OUT_BITS = 56;

    typedef enum logic [1:0] {
        CMD_CTRL  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [1:0] CODE_VREAD = 2'd0;
    localparam logic [1:0] CODE_REG   = 2'd2;
    localparam logic [1:0] CODE_CRAM  = 2'd3;

    localparam logic [1:0] LINE_192 = 2'd0;
    localparam logic [1:0] LINE_224 = 2'd1;
    localparam logic [1:0] LINE_240 = 2'd2;

    localparam logic [7:0] MODE0_RESET = 8'h36;
    localparam logic [7:0] MODE1_RESET = 8'h80;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } t_state;

    typedef struct packed {
        logic                 we;
        logic [VRAM_AW-1:0]   waddr;
        logic [7:0]           wdata;
        logic                 re;
        logic [VRAM_AW-1:0]   raddr;
    } t_ram_req;

endpackage

@@ src/vpi_ram.sv @@
// ============================================================================
// Generic single-clock RAM
// One write port, one read port, read data registered.
// ============================================================================
module vpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/video_port_interface.sv @@
// ============================================================================
// Video port interface
// CPU control/data port decoder with video memory, read buffer and
// mode register line-mode decode.
// ============================================================================
//  channel | dir | signals                      | content
//  --------+-----+------------------------------+-----------------------------
//  s       | in  | tvalid tready tdata tuser    | port access (cmd, wdata)
//  m       | out | tvalid tready tdata          | access result fields
//
//  Reads of video memory (data read, code-0 control pair) pass through the
//  read wait state: the memory port issues the read at the transfer, the
//  buffer refills in the next cycle. All other accesses produce their result
//  without the wait state. After reset a clearing pass zeroes video memory,
//  during which no transfer is taken on s.
//  A result held on m stalls s until it is taken.
// ============================================================================
`include "video_port_interface_macros.svh"

module video_port_interface (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [7:0]                   i_s_tdata,   // [7:0] wdata
    input  logic [1:0]                   i_s_tuser,   // [1:0] cmd
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [7:0] read_data, [21:8] address, [23:22] code, [24] reg_written,
    // [28:25] reg_index, [36:29] reg_value, [37] cram_written,
    // [42:38] cram_index, [50:43] cram_value, [52:51] line_sel, [55:53] zero
    output logic [vpi_pkg::OUT_BITS-1:0] o_m_tdata
);

    import vpi_pkg::*;

    t_state               r_state, n_state;
    logic [VRAM_AW-1:0]   r_clr_addr, n_clr_addr;
    logic [15:0]          r_cmdw, n_cmdw;
    logic                 r_first, n_first;
    logic [7:0]           r_rbuf, n_rbuf;
    logic [7:0]           r_mode0, n_mode0;
    logic [7:0]           r_mode1, n_mode1;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]  r_out, n_out;

    logic                 s_acc;
    logic                 m_acc;
    t_cmd                 cmd;
    logic [7:0]           wdata;
    t_ram_req             item_req;
    t_ram_req             ram_req;
    logic [7:0]           ram_rdata;

    logic [15:0]          c_cmdw;
    logic [7:0]           c_rd;
    logic                 c_rw;
    logic [3:0]           c_ri;
    logic [7:0]           c_rv;
    logic                 c_cw;
    logic [4:0]           c_ci;
    logic [7:0]           c_cv;
    logic [1:0]           c_line;

    function automatic logic [15:0] advance(input logic [15:0] w);
        advance = {w[15:14], w[13:0] + 14'd1};
    endfunction

    function automatic logic [1:0] lines_decode(input logic [7:0] m0, input logic [7:0] m1);
        logic m4;
        m4 = (m0 & 8'h06) == 8'h06;
        if (m4 && m1[4]) begin
            lines_decode = LINE_224;
        end else if (m4 && m1[2]) begin
            lines_decode = LINE_240;
        end else begin
            lines_decode = LINE_192;
        end
    endfunction

    assign cmd        = t_cmd'(i_s_tuser);
    assign wdata      = i_s_tdata;
    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = r_out_valid && i_m_tready;

    // decode one access
    always_comb begin
        c_cmdw   = r_cmdw;
        n_first  = r_first;
        n_rbuf   = r_rbuf;
        n_mode0  = r_mode0;
        n_mode1  = r_mode1;
        c_rd     = 8'd0;
        c_rw     = 1'b0;
        c_ri     = 4'd0;
        c_rv     = 8'd0;
        c_cw     = 1'b0;
        c_ci     = 5'd0;
        c_cv     = 8'd0;
        item_req = '0;
        case (cmd)
            CMD_CTRL: begin
                if (r_first) begin
                    c_cmdw  = {r_cmdw[15:8], wdata};
                    n_first = 1'b0;
                end else begin
                    n_first = 1'b1;
                    c_cmdw  = {wdata, r_cmdw[7:0]};
                    if (wdata[7:6] == CODE_VREAD) begin
                        item_req.re    = 1'b1;
                        item_req.raddr = c_cmdw[VRAM_AW-1:0];
                        c_cmdw         = advance(c_cmdw);
                    end else if (wdata[7:6] == CODE_REG) begin
                        if (32'(wdata[3:0]) < REG_COUNT) begin
                            c_rw = 1'b1;
                            c_ri = wdata[3:0];
                            c_rv = r_cmdw[7:0];
                            if (wdata[3:0] == 4'd0) begin
                                n_mode0 = r_cmdw[7:0];
                            end
                            if (wdata[3:0] == 4'd1) begin
                                n_mode1 = r_cmdw[7:0];
                            end
                        end
                    end
                end
            end
            CMD_WRITE: begin
                n_first = 1'b1;
                n_rbuf  = wdata;
                if (r_cmdw[15:14] == CODE_CRAM) begin
                    c_cw = 1'b1;
                    c_ci = 5'(r_cmdw[CRAM_AW-1:0]);
                    c_cv = wdata;
                end else begin
                    item_req.we    = 1'b1;
                    item_req.waddr = r_cmdw[VRAM_AW-1:0];
                    item_req.wdata = wdata;
                end
                c_cmdw = advance(r_cmdw);
            end
            CMD_READ: begin
                n_first        = 1'b1;
                c_rd           = r_rbuf;
                item_req.re    = 1'b1;
                item_req.raddr = r_cmdw[VRAM_AW-1:0];
                c_cmdw         = advance(r_cmdw);
            end
            default: begin
            end
        endcase
        c_line = lines_decode(n_mode0, n_mode1);
    end

    // memory port: clearing pass, then item accesses
    always_comb begin
        ram_req = '0;
        if (r_state == ST_CLEAR) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = r_clr_addr;
        end else if (s_acc) begin
            ram_req = item_req;
        end
    end

    vpi_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cmdw      = r_cmdw;
        n_out       = r_out;
        n_out_valid = r_out_valid && !m_acc;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + VRAM_AW'(1);
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    n_cmdw = c_cmdw;
                    n_out  = {3'd0, c_line, c_cv, c_ci, c_cw, c_rv, c_ri, c_rw,
                              c_cmdw[15:14], c_cmdw[13:0], c_rd};
                    if (item_req.re) begin
                        n_state = ST_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_cmdw      <= 16'd0;
            r_first     <= 1'b1;
            r_rbuf      <= 8'd0;
            r_mode0     <= MODE0_RESET;
            r_mode1     <= MODE1_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cmdw      <= n_cmdw;
            r_out_valid <= n_out_valid;
            if (s_acc) begin
                r_first <= n_first;
                r_rbuf  <= n_rbuf;
                r_mode0 <= n_mode0;
                r_mode1 <= n_mode1;
            end
            if (r_state == ST_READ) begin
                r_rbuf <= ram_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    `VPI_ASSERT_IMP(a_no_transfer_in_clear, r_state == ST_CLEAR, !o_s_tready)
    `VPI_ASSERT_NXT(a_read_enters_wait, s_acc && cmd == CMD_READ, r_state == ST_READ)
    `VPI_ASSERT_IMP(a_out_free_in_wait, r_state == ST_READ, !r_out_valid)
    `VPI_ASSERT_NXT(a_first_byte_latch, s_acc && cmd == CMD_CTRL && r_first, !r_first)
    `VPI_ASSERT_NXT(a_wait_delivers, r_state == ST_READ, r_out_valid && r_state == ST_IDLE)

endmodule

@@ tb/sv/video_port_interface_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Video port interface testbench
// Drives control, data write, data read and ignored port accesses through the
// slave stream, predicts every result from a local copy of the address word,
// byte latch, read buffer, mode registers and both memories, and compares
// each result on the master stream field by field. Directed cases cover the
// register index range, address wrap, color memory, latch behavior and the
// line-mode decode; random address setups with data bursts, register writes
// and stray accesses follow, with random gaps and stalls on both streams.
// ============================================================================
module video_port_interface_tb;
    import vpi_pkg::*;

    typedef struct packed {
        logic [2:0]  spare;
        logic [1:0]  line_sel;
        logic [7:0]  cram_value;
        logic [4:0]  cram_index;
        logic        cram_written;
        logic [7:0]  reg_value;
        logic [3:0]  reg_index;
        logic        reg_written;
        logic [1:0]  code;
        logic [13:0] address;
        logic [7:0]  read_data;
    } t_access_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata;   // [7:0] wdata
    logic [1:0]          i_s_tuser;   // [1:0] cmd
    logic                o_m_tvalid;
    logic                i_m_tready;
    // [7:0] read_data, [21:8] address, [23:22] code, [24] reg_written,
    // [28:25] reg_index, [36:29] reg_value, [37] cram_written,
    // [42:38] cram_index, [50:43] cram_value, [52:51] line_sel, [55:53] zero
    logic [OUT_BITS-1:0] o_m_tdata;

    logic [7:0]     vram_image [VRAM_DEPTH];
    logic [7:0]     cram_image [CRAM_DEPTH];
    logic [7:0]     mode_regs  [REG_COUNT];
    logic [15:0]    port_word;
    logic           low_byte_pending;
    logic [7:0]     prefetch_byte;

    t_access_result expected_results [$];
    int             mismatch_count;
    int             items_sent;
    bit             sender_idle;
    bit             receiver_idle;

    video_port_interface dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_800_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic reset_image();
        for (int i = 0; i < VRAM_DEPTH; i++) vram_image[i] = 8'h00;
        for (int i = 0; i < CRAM_DEPTH; i++) cram_image[i] = 8'h00;
        for (int i = 0; i < REG_COUNT; i++) mode_regs[i] = 8'hFF;
        mode_regs[0]     = MODE0_RESET;
        mode_regs[1]     = MODE1_RESET;
        port_word        = 16'h0000;
        low_byte_pending = 1'b1;
        prefetch_byte    = 8'h00;
    endtask

    function automatic logic [1:0] decoded_lines();
        logic m4;
        m4 = (mode_regs[0] & 8'h06) == 8'h06;
        if (m4 && (mode_regs[1] & 8'h10) == 8'h10) return LINE_224;
        if (m4 && (mode_regs[1] & 8'h04) == 8'h04) return LINE_240;
        return LINE_192;
    endfunction

    function automatic t_access_result predict_access(t_cmd kind, logic [7:0] wbyte);
        t_access_result r;
        logic [3:0]     idx;
        r = '0;
        case (kind)
            CMD_CTRL: begin
                if (low_byte_pending) begin
                    port_word[7:0]   = wbyte;
                    low_byte_pending = 1'b0;
                end else begin
                    low_byte_pending = 1'b1;
                    port_word[15:8]  = wbyte;
                    if (port_word[15:14] == CODE_VREAD) begin
                        prefetch_byte    = vram_image[port_word[VRAM_AW-1:0]];
                        port_word[13:0]  = port_word[13:0] + 14'd1;
                    end else if (port_word[15:14] == CODE_REG) begin
                        idx = wbyte[3:0];
                        if (idx < REG_COUNT) begin
                            mode_regs[idx] = port_word[7:0];
                            r.reg_written  = 1'b1;
                            r.reg_index    = idx;
                            r.reg_value    = port_word[7:0];
                        end
                    end
                end
            end
            CMD_WRITE: begin
                low_byte_pending = 1'b1;
                prefetch_byte    = wbyte;
                if (port_word[15:14] == CODE_CRAM) begin
                    cram_image[port_word[CRAM_AW-1:0]] = wbyte;
                    r.cram_written = 1'b1;
                    r.cram_index   = port_word[CRAM_AW-1:0];
                    r.cram_value   = wbyte;
                end else begin
                    vram_image[port_word[VRAM_AW-1:0]] = wbyte;
                end
                port_word[13:0] = port_word[13:0] + 14'd1;
            end
            CMD_READ: begin
                low_byte_pending = 1'b1;
                r.read_data      = prefetch_byte;
                prefetch_byte    = vram_image[port_word[VRAM_AW-1:0]];
                port_word[13:0]  = port_word[13:0] + 14'd1;
            end
            default: ;
        endcase
        r.address  = port_word[13:0];
        r.code     = port_word[15:14];
        r.line_sel = decoded_lines();
        return r;
    endfunction

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected 0x%0h actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_access_result got;
        t_access_result want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            got = o_m_tdata;
            if (expected_results.size() == 0) begin
                $error("result 0x%0h with nothing expected", got);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
                compare_field("address", 32'(want.address), 32'(got.address));
                compare_field("code", 32'(want.code), 32'(got.code));
                compare_field("reg_written", 32'(want.reg_written), 32'(got.reg_written));
                compare_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
                compare_field("reg_value", 32'(want.reg_value), 32'(got.reg_value));
                compare_field("cram_written", 32'(want.cram_written),
                              32'(got.cram_written));
                compare_field("cram_index", 32'(want.cram_index), 32'(got.cram_index));
                compare_field("cram_value", 32'(want.cram_value), 32'(got.cram_value));
                compare_field("line_sel", 32'(want.line_sel), 32'(got.line_sel));
                compare_field("spare", 32'(want.spare), 32'(got.spare));
            end
        end
    end

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = receiver_idle ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid === 1'b1 && i_m_tready));
            @(negedge i_clk);
        end
    end

    task automatic send_access(t_cmd kind, logic [7:0] wbyte);
        int gap;
        gap = sender_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= wbyte;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready === 1'b1));
        expected_results.push_back(predict_access(kind, wbyte));
        if (kind != CMD_NONE) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic set_address(logic [13:0] addr, logic [1:0] code_sel);
        send_access(CMD_CTRL, addr[7:0]);
        send_access(CMD_CTRL, {code_sel, addr[13:8]});
    endtask

    task automatic write_mode_reg(logic [3:0] idx, logic [7:0] value, logic [1:0] high_bits);
        send_access(CMD_CTRL, value);
        send_access(CMD_CTRL, {CODE_REG, high_bits, idx});
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_access(CMD_READ, 8'hFF);
        send_access(CMD_NONE, 8'hA5);
    endtask

    task automatic test_mode_registers();
        write_mode_reg(4'd1, 8'h10, 2'b00);
        write_mode_reg(4'd1, 8'h04, 2'b11);
        write_mode_reg(4'd10, 8'hFF, 2'b01);
        write_mode_reg(4'd11, 8'h00, 2'b10);
        write_mode_reg(4'd15, 8'h5A, 2'b11);
        write_mode_reg(4'd0, 8'h00, 2'b00);
    endtask

    task automatic test_vram_wrap();
        set_address(14'h3FFF, 2'd1);
        send_access(CMD_WRITE, 8'hA5);
        send_access(CMD_WRITE, 8'h5A);
        set_address(14'h3FFF, CODE_VREAD);
        send_access(CMD_READ, 8'h00);
        send_access(CMD_READ, 8'hFF);
    endtask

    task automatic test_color_memory();
        set_address(14'h001F, CODE_CRAM);
        send_access(CMD_WRITE, 8'hFF);
        send_access(CMD_WRITE, 8'h00);
    endtask

    task automatic test_latch_reset();
        send_access(CMD_CTRL, 8'h12);
        send_access(CMD_NONE, 8'h34);
        send_access(CMD_WRITE, 8'h3C);
        send_access(CMD_CTRL, 8'h40);
        send_access(CMD_READ, 8'h00);
    endtask

    task automatic run_traffic(int target);
        int          stop_at;
        int          shape;
        int          burst;
        logic [13:0] addr;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            shape = $urandom_range(0, 9);
            if (shape <= 5) begin
                case ($urandom_range(0, 2))
                    0:       addr = 14'($urandom_range(0, 63));
                    1:       addr = 14'(14'h3FFF - $urandom_range(0, 7));
                    default: addr = 14'($urandom_range(0, 16383));
                endcase
                set_address(addr, 2'($urandom_range(0, 3)));
                burst = $urandom_range(0, 8);
                repeat (burst) begin
                    send_access(t_cmd'($urandom_range(0, 1) ? CMD_WRITE : CMD_READ),
                                8'($urandom_range(0, 255)));
                end
            end else if (shape <= 7) begin
                write_mode_reg(4'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                       : $urandom_range(0, 15)),
                               8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
            end else if (shape == 8) begin
                send_access(CMD_CTRL, 8'($urandom_range(0, 255)));
                send_access(t_cmd'($urandom_range(0, 1) ? CMD_WRITE : CMD_READ),
                            8'($urandom_range(0, 255)));
            end else begin
                send_access(t_cmd'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_traffic();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        run_traffic(200);
        drain_results();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        run_traffic(100);
        sender_idle   = 1'b1;
        run_traffic(100);
        sender_idle   = 1'b0;
        receiver_idle = 1'b1;
        run_traffic(110);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = 8'h00;
        i_s_tuser      = CMD_CTRL;
        i_m_tready     = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        sender_idle    = 1'b1;
        receiver_idle  = 1'b1;
        reset_image();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_mode_registers();
        test_vram_wrap();
        test_color_memory();
        test_latch_reset();
        test_random_traffic();

        drain_results();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
